// ----- sv/salc_pkg.sv -----
package salc_pkg;

    // access kinds
    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_STORE  = 2'd1;
    localparam logic [1:0] ACT_MODIFY = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS        = 2'd2;

    localparam int CFG_DATA_WIDTH = 6;
    localparam int CNT_WIDTH      = 32;

    // result flags carried from back end to output
    typedef struct packed {
        logic hit;
        logic evicted;
        logic second_hit;
    } flags_t;

endpackage

// ----- sv/salc_ram.sv -----
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/salc_front.sv -----
module salc_front #(
    parameter int MAX_SET_BITS = 8,
    parameter int ADDR_WIDTH   = 64,
    parameter int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            action,
    input  logic [ADDR_WIDTH-1:0] address,
    input  logic [3:0]            set_bits,
    input  logic [5:0]            offset_bits,
    output logic                  q_valid,
    input  logic                  q_ready,
    output logic                  q_modify,
    output logic [SET_W-1:0]      q_set,
    output logic [ADDR_WIDTH-1:0] q_tag
);

    localparam int SB_W = $clog2(MAX_SET_BITS + 1) + 1;

    logic [1:0]            cnt_reg, cnt_next;
    logic                  wp_reg, rp_reg;
    logic                  mod_reg [2];
    logic [SET_W-1:0]      set_reg [2];
    logic [ADDR_WIDTH-1:0] tag_reg [2];

    logic [SB_W-1:0]       sb;
    logic [ADDR_WIDTH-1:0] shifted;
    logic [ADDR_WIDTH-1:0] set_full;
    logic [ADDR_WIDTH-1:0] tag_c;
    logic [6:0]            tshift;

    // clamp set bits and split the address
    always_comb
    begin
        if ({1'b0, set_bits} > 5'(MAX_SET_BITS))
        begin
            sb = SB_W'(MAX_SET_BITS);
        end
        else
        begin
            sb = SB_W'(set_bits);
        end
        shifted  = (7'(offset_bits) >= 7'(ADDR_WIDTH)) ? '0 : (address >> offset_bits);
        set_full = shifted & ((ADDR_WIDTH'(1) << sb) - ADDR_WIDTH'(1));
        tshift   = 7'(offset_bits) + 7'(sb);
        tag_c    = (tshift >= 7'(ADDR_WIDTH)) ? '0 : (address >> tshift);
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_modify = mod_reg[rp_reg];
    assign q_set    = set_reg[rp_reg];
    assign q_tag    = tag_reg[rp_reg];

    // two-entry request queue
    always_comb
    begin
        cnt_next = cnt_reg + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (in_valid && in_ready)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_valid && q_ready)
            begin
                rp_reg <= ~rp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mod_reg[wp_reg] <= (action == salc_pkg::ACT_MODIFY);
            set_reg[wp_reg] <= SET_W'(set_full);
            tag_reg[wp_reg] <= tag_c;
        end
    end

endmodule

// ----- sv/salc_back.sv -----
module salc_back #(
    parameter int MAX_WAYS   = 8,
    parameter int ADDR_WIDTH = 64,
    parameter int SET_W      = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [3:0]                    ways,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  logic                          q_modify,
    input  logic [SET_W-1:0]              q_set,
    input  logic [ADDR_WIDTH-1:0]         q_tag,
    output logic                          out_valid,
    input  logic                          out_ready,
    output salc_pkg::flags_t              out_flags,
    output logic [salc_pkg::CNT_WIDTH-1:0] out_hits,
    output logic [salc_pkg::CNT_WIDTH-1:0] out_misses,
    output logic [salc_pkg::CNT_WIDTH-1:0] out_evicts
);

    localparam int NSETS = 1 << SET_W;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RK_W  = WAY_W;
    localparam int CW    = salc_pkg::CNT_WIDTH;
    localparam int META  = MAX_WAYS * (RK_W + 1);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_WRITE = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [SET_W-1:0]  clr_reg;
    logic [SET_W-1:0]  set_reg;
    logic [ADDR_WIDTH-1:0] tag_reg;
    logic              mod_reg;
    logic [CW-1:0]     hits_reg, misses_reg, evicts_reg;
    logic              ovalid_reg;
    salc_pkg::flags_t  oflags_reg;

    logic [MAX_WAYS*ADDR_WIDTH-1:0] tag_rd;
    logic [META-1:0]   meta_rd;
    logic [META-1:0]   meta_wr;
    logic              meta_we;
    logic [SET_W-1:0]  meta_wa;
    logic [MAX_WAYS-1:0] tag_we;
    logic [SET_W-1:0]  rd_addr;

    logic [4:0]        nways;
    logic              found, empty;
    logic [WAY_W-1:0]  w_sel, w_hit, w_emp, w_lru;
    logic [RK_W-1:0]   best, limit;
    logic              lv [MAX_WAYS];
    logic [RK_W-1:0]   rk [MAX_WAYS];
    logic              nlv [MAX_WAYS];
    logic [RK_W-1:0]   nrk [MAX_WAYS];

    // tag memory per way, shared metadata memory (valid, rank per way)
    for (genvar g = 0; g < MAX_WAYS; g++)
    begin : g_tag
        salc_ram #(.WIDTH(ADDR_WIDTH), .DEPTH(NSETS)) u_tag (
            .clk(clk), .we(tag_we[g]), .waddr(set_reg), .wdata(tag_reg),
            .raddr(rd_addr), .rdata(tag_rd[g*ADDR_WIDTH +: ADDR_WIDTH])
        );
    end

    salc_ram #(.WIDTH(META), .DEPTH(NSETS)) u_meta (
        .clk(clk), .we(meta_we), .waddr(meta_wa), .wdata(meta_wr),
        .raddr(rd_addr), .rdata(meta_rd)
    );

    // hold the read address on the request's set until the update is done
    assign rd_addr = (state_reg == ST_IDLE) ? q_set : set_reg;

    // clamp associativity
    always_comb
    begin
        if (ways == 4'd0)
        begin
            nways = 5'd1;
        end
        else if ({1'b0, ways} > 5'(MAX_WAYS))
        begin
            nways = 5'(MAX_WAYS);
        end
        else
        begin
            nways = {1'b0, ways};
        end
    end

    // look up the set, pick the way and age the others
    always_comb
    begin
        found = 1'b0;
        empty = 1'b0;
        w_hit = '0;
        w_emp = '0;
        w_lru = '0;
        best  = '0;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            lv[i] = meta_rd[i*(RK_W+1) + RK_W];
            rk[i] = meta_rd[i*(RK_W+1) +: RK_W];
        end
        for (int i = MAX_WAYS - 1; i >= 0; i--)
        begin
            if (5'(i) < nways)
            begin
                if (lv[i] && tag_rd[i*ADDR_WIDTH +: ADDR_WIDTH] == tag_reg)
                begin
                    found = 1'b1;
                    w_hit = WAY_W'(i);
                end
                if (!lv[i])
                begin
                    empty = 1'b1;
                    w_emp = WAY_W'(i);
                end
            end
        end
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (5'(i) < nways && rk[i] > best)
            begin
                best  = rk[i];
                w_lru = WAY_W'(i);
            end
        end
        if (found)
        begin
            w_sel = w_hit;
        end
        else if (empty)
        begin
            w_sel = w_emp;
        end
        else
        begin
            w_sel = w_lru;
        end
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            nlv[i] = lv[i];
            nrk[i] = rk[i];
        end
        limit = rk[w_sel];
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (5'(i) < nways && WAY_W'(i) != w_sel && lv[i]
                && (( !found && empty) || rk[i] < limit)
                && rk[i] != RK_W'(MAX_WAYS - 1))
            begin
                nrk[i] = rk[i] + RK_W'(1);
            end
        end
        nrk[w_sel] = '0;
        nlv[w_sel] = 1'b1;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            meta_wr[i*(RK_W+1) + RK_W]  = nlv[i];
            meta_wr[i*(RK_W+1) +: RK_W] = nrk[i];
        end
        if (state_reg == ST_CLEAR)
        begin
            meta_wr = '0;
        end
    end

    assign meta_we = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);
    assign meta_wa = (state_reg == ST_CLEAR) ? clr_reg : set_reg;
    always_comb
    begin
        tag_we = '0;
        if (state_reg == ST_WRITE && !found)
        begin
            tag_we[w_sel] = 1'b1;
        end
    end

    assign q_ready   = (state_reg == ST_IDLE) && !ovalid_reg;
    assign out_valid = ovalid_reg;
    assign out_flags = oflags_reg;
    assign out_hits  = hits_reg;
    assign out_misses = misses_reg;
    assign out_evicts = evicts_reg;

    // sequence clear, read and update
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == SET_W'(NSETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid && q_ready)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:  state_next = ST_WRITE;
            ST_WRITE: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            hits_reg   <= '0;
            misses_reg <= '0;
            evicts_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + SET_W'(1);
            end
            if (ovalid_reg && out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
            if (state_reg == ST_WRITE)
            begin
                ovalid_reg <= 1'b1;
                if (found)
                begin
                    hits_reg <= hits_reg + CW'(hits_reg != '1) + CW'(mod_reg
                                && (hits_reg + CW'(1)) != '1 && hits_reg != '1);
                end
                else
                begin
                    hits_reg <= hits_reg + CW'(mod_reg && hits_reg != '1);
                    misses_reg <= misses_reg + CW'(misses_reg != '1);
                    if (!empty)
                    begin
                        evicts_reg <= evicts_reg + CW'(evicts_reg != '1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
        begin
            set_reg <= q_set;
            tag_reg <= q_tag;
            mod_reg <= q_modify;
        end
        if (state_reg == ST_WRITE)
        begin
            oflags_reg.hit        <= found;
            oflags_reg.evicted    <= !found && !empty;
            oflags_reg.second_hit <= mod_reg;
        end
    end

`ifndef SYNTHESIS
    a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !q_ready)
        else $error("queue popped while busy");
    a_write_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_WRITE))
        else $error("read not followed by update");
    a_result_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |=> out_valid)
        else $error("result missing after update");
`endif

endmodule

// ----- sv/set_assoc_lru_cache_sim.sv -----
// Path from request accept to result valid: queue hand-off, read, update.
// Requests: the back-end sequencer takes a new one only after the hand-off, metadata
// read, write-back and result hand-off of the previous request are done.
// Reset: counters clear, config returns to set_bits 4, offset_bits 4, ways 1;
// a clearing pass over every set zeroes valid and rank metadata.
module set_assoc_lru_cache_sim #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_WIDTH   = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [salc_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            action,
    input  logic [ADDR_WIDTH-1:0] address,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  hit,
    output logic                  evicted,
    output logic                  second_hit,
    output logic [31:0]           hit_total,
    output logic [31:0]           miss_total,
    output logic [31:0]           eviction_total
);

    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

    logic [3:0] set_bits_reg;
    logic [5:0] offset_bits_reg;
    logic [3:0] ways_reg;

    logic                  q_valid, q_ready, q_modify;
    logic [SET_W-1:0]      q_set;
    logic [ADDR_WIDTH-1:0] q_tag;
    salc_pkg::flags_t      flags;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg    <= 4'd4;
            offset_bits_reg <= 6'd4;
            ways_reg        <= 4'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                salc_pkg::CFG_SET_BITS:    set_bits_reg    <= cfg_data[3:0];
                salc_pkg::CFG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                salc_pkg::CFG_WAYS:        ways_reg        <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    salc_front #(.MAX_SET_BITS(MAX_SET_BITS), .ADDR_WIDTH(ADDR_WIDTH), .SET_W(SET_W)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .address(address), .set_bits(set_bits_reg),
        .offset_bits(offset_bits_reg), .q_valid(q_valid), .q_ready(q_ready),
        .q_modify(q_modify), .q_set(q_set), .q_tag(q_tag)
    );

    salc_back #(.MAX_WAYS(MAX_WAYS), .ADDR_WIDTH(ADDR_WIDTH), .SET_W(SET_W)) u_back (
        .clk(clk), .rst_n(rst_n), .ways(ways_reg), .q_valid(q_valid),
        .q_ready(q_ready), .q_modify(q_modify), .q_set(q_set), .q_tag(q_tag),
        .out_valid(out_valid), .out_ready(out_ready), .out_flags(flags),
        .out_hits(hit_total), .out_misses(miss_total), .out_evicts(eviction_total)
    );

    assign hit        = flags.hit;
    assign evicted    = flags.evicted;
    assign second_hit = flags.second_hit;

endmodule
